>>> rtl/core/dlp_pkg.sv
// ----------------------------------------------------------------------------
// dlp_pkg
// Shared types and codes for the longest-chain block.
// ----------------------------------------------------------------------------
package dlp_pkg;

    localparam int NODES = 64;
    localparam int IDX_W = 6;
    localparam int LEN_W = 7;

    // request codes
    localparam logic [1:0] OP_NODE  = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_PATH  = 2'd0;
    localparam logic [1:0] ST_CYCLE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [LEN_W-1:0] NO_HOP = LEN_W'(NODES);

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
    } t_cmd;

    // queue status seen by the back end
    typedef struct packed {
        logic avail;
        t_cmd cmd;
    } t_qhead;

endpackage

>>> rtl/core/dlp_front.sv
// ----------------------------------------------------------------------------
// dlp_front
// Input side: takes items, decodes the request and queues them for the
// back end in a four-entry queue.
// ----------------------------------------------------------------------------
module dlp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic [5:0]         i_src_node,
    input  logic [5:0]         i_dst_node,
    input  logic               i_pop,
    output dlp_pkg::t_qhead    o_head
);

    dlp_pkg::t_cmd r_q [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       push;
    logic       pop;
    dlp_pkg::t_cmd cmd;

    always_comb begin
        cmd.op  = i_req_type;
        cmd.src = i_src_node;
        // only an edge carries a destination
        cmd.dst = (i_req_type == dlp_pkg::OP_EDGE) ? i_dst_node : '0;
    end

    assign o_stall = (r_cnt == 3'd4);
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

    assign o_head.avail = (r_cnt != 3'd0);
    assign o_head.cmd   = r_q[r_rd];

endmodule

>>> rtl/core/dlp_back.sv
// ----------------------------------------------------------------------------
// dlp_back
// Execution side: graph storage, Kahn sort, longest-chain pass, and the
// output register.
// ----------------------------------------------------------------------------
module dlp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dlp_pkg::t_qhead               i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [dlp_pkg::IDX_W-1:0]     o_path_node,
    output logic [dlp_pkg::LEN_W-1:0]     o_chain_length,
    output logic                          o_last
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_EWR       = 4'd1;
    localparam logic [3:0] S_DEG_RD    = 4'd2;
    localparam logic [3:0] S_DEG_ADD   = 4'd3;
    localparam logic [3:0] S_PICK      = 4'd4;
    localparam logic [3:0] S_DEC       = 4'd5;
    localparam logic [3:0] S_DP_TOP    = 4'd6;
    localparam logic [3:0] S_DP_ROW    = 4'd7;
    localparam logic [3:0] S_DP_LOAD   = 4'd8;
    localparam logic [3:0] S_DP_RD     = 4'd9;
    localparam logic [3:0] S_DP_CMP    = 4'd10;
    localparam logic [3:0] S_WALK_RD   = 4'd11;
    localparam logic [3:0] S_WALK_EMIT = 4'd12;
    localparam logic [3:0] S_EMIT1     = 4'd13;

    localparam int N  = dlp_pkg::NODES;
    localparam int IW = dlp_pkg::IDX_W;
    localparam int LW = dlp_pkg::LEN_W;

    function automatic logic [IW-1:0] low_idx(input logic [N-1:0] m);
        logic [IW-1:0] r;
        r = '0;
        for (int k = N - 1; k >= 0; k--) begin
            if (m[k]) begin
                r = IW'(k);
            end
        end
        return r;
    endfunction

    // memories
    logic [N-1:0]  edge_mem [N];
    logic [IW-1:0] topo_mem [N];
    logic [LW-1:0] bl_mem   [N];
    logic [LW-1:0] nh_mem   [N];

    logic [3:0]    r_state;
    logic [N-1:0]  r_present;
    logic [N-1:0]  r_rowv;
    logic [N-1:0]  r_done;
    logic [LW-1:0] r_indeg [N];
    logic [IW-1:0] r_idx;
    logic [LW-1:0] r_ntopo;
    logic [IW-1:0] r_pos;
    logic [IW-1:0] r_u;
    logic [IW-1:0] r_v;
    logic [N-1:0]  r_mask;
    logic [LW-1:0] r_cur_len;
    logic [LW-1:0] r_cur_hop;
    logic [LW-1:0] r_max;
    logic [IW-1:0] r_start;
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_count;
    logic [1:0]    r_pend;
    dlp_pkg::t_cmd r_cmd;

    // memory read registers
    logic [N-1:0]  r_erow;
    logic          r_erv;
    logic [IW-1:0] r_topo_q;
    logic [LW-1:0] r_bl_q;
    logic [LW-1:0] r_nh_q;

    logic          r_ovalid;
    logic [1:0]    r_ostatus;
    logic [IW-1:0] r_onode;
    logic [LW-1:0] r_olen;
    logic          r_olast;

    logic [IW-1:0] e_raddr;
    logic [N-1:0]  row;
    logic [N-1:0]  cand;
    logic          out_free;
    logic          emit;
    logic          fin;
    logic [LW-1:0] cand_len;

    assign row      = r_erv ? r_erow : '0;
    assign out_free = !r_ovalid || !i_stall;
    assign emit     = out_free && (r_state == S_WALK_EMIT || r_state == S_EMIT1);
    assign o_pop    = (r_state == S_IDLE) && i_head.avail;
    assign fin      = (r_nh_q == dlp_pkg::NO_HOP) || (r_count == IW'(N - 1));
    assign cand_len = r_bl_q + LW'(1);

    always_comb begin
        for (int k = 0; k < N; k++) begin
            cand[k] = r_present[k] && !r_done[k] && (r_indeg[k] == '0);
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:   e_raddr = i_head.cmd.src;
            S_DEG_RD: e_raddr = r_idx;
            S_PICK:   e_raddr = low_idx(cand);
            S_DP_ROW: e_raddr = r_topo_q;
            default:  e_raddr = r_cmd.src;
        endcase
    end

    // edge rows: one read, one write port
    always_ff @(posedge i_clk) begin
        r_erow <= edge_mem[e_raddr];
        r_erv  <= r_rowv[e_raddr];
        if (r_state == S_EWR) begin
            edge_mem[r_cmd.src] <= row | (N'(1) << r_cmd.dst);
        end
    end

    always_ff @(posedge i_clk) begin
        r_topo_q <= topo_mem[r_pos];
        if (r_state == S_PICK && cand != '0) begin
            topo_mem[r_ntopo[IW-1:0]] <= low_idx(cand);
        end
    end

    always_ff @(posedge i_clk) begin
        r_bl_q <= bl_mem[low_idx(r_mask)];
        r_nh_q <= nh_mem[r_cur];
        if (r_state == S_DP_RD && r_mask == '0) begin
            bl_mem[r_u] <= r_cur_len;
            nh_mem[r_u] <= r_cur_hop;
        end
    end

    // output valid: set on an emit, dropped once the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (out_free) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_rowv    <= '0;
            r_count   <= '0;
            r_cur     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.avail) begin
                        r_cmd <= i_head.cmd;
                        unique case (i_head.cmd.op)
                            dlp_pkg::OP_NODE: begin
                                r_present[i_head.cmd.src] <= 1'b1;
                            end
                            dlp_pkg::OP_EDGE: begin
                                r_present[i_head.cmd.src] <= 1'b1;
                                r_present[i_head.cmd.dst] <= 1'b1;
                                r_state <= S_EWR;
                            end
                            dlp_pkg::OP_CLEAR: begin
                                r_present <= '0;
                                r_rowv    <= '0;
                            end
                            default: begin
                                if (r_present == '0) begin
                                    r_pend  <= dlp_pkg::ST_EMPTY;
                                    r_state <= S_EMIT1;
                                end else begin
                                    for (int k = 0; k < N; k++) begin
                                        r_indeg[k] <= '0;
                                    end
                                    r_idx   <= '0;
                                    r_done  <= '0;
                                    r_ntopo <= '0;
                                    r_state <= S_DEG_RD;
                                end
                            end
                        endcase
                    end
                end
                S_EWR: begin
                    r_rowv[r_cmd.src] <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DEG_RD: begin
                    r_state <= S_DEG_ADD;
                end
                S_DEG_ADD: begin
                    for (int k = 0; k < N; k++) begin
                        r_indeg[k] <= r_indeg[k] + LW'(row[k]);
                    end
                    r_idx   <= r_idx + IW'(1);
                    r_state <= (r_idx == IW'(N - 1)) ? S_PICK : S_DEG_RD;
                end
                S_PICK: begin
                    if (cand != '0) begin
                        r_done[low_idx(cand)] <= 1'b1;
                        r_ntopo <= r_ntopo + LW'(1);
                        r_state <= S_DEC;
                    end else if (r_done == r_present) begin
                        r_pos   <= IW'(r_ntopo - LW'(1));
                        r_max   <= '0;
                        r_start <= '0;
                        r_state <= S_DP_TOP;
                    end else begin
                        r_pend  <= dlp_pkg::ST_CYCLE;
                        r_state <= S_EMIT1;
                    end
                end
                S_DEC: begin
                    for (int k = 0; k < N; k++) begin
                        r_indeg[k] <= r_indeg[k] - LW'(row[k]);
                    end
                    r_state <= S_PICK;
                end
                S_DP_TOP: begin
                    r_state <= S_DP_ROW;
                end
                S_DP_ROW: begin
                    r_u       <= r_topo_q;
                    r_cur_len <= LW'(1);
                    r_cur_hop <= dlp_pkg::NO_HOP;
                    r_state   <= S_DP_LOAD;
                end
                S_DP_LOAD: begin
                    r_mask  <= row;
                    r_state <= S_DP_RD;
                end
                S_DP_RD: begin
                    if (r_mask != '0) begin
                        r_v <= low_idx(r_mask);
                        r_mask[low_idx(r_mask)] <= 1'b0;
                        r_state <= S_DP_CMP;
                    end else begin
                        // chain from r_u is final; lowest index wins a tie
                        if (r_cur_len > r_max || (r_cur_len == r_max && r_u < r_start)) begin
                            r_max   <= r_cur_len;
                            r_start <= r_u;
                        end
                        if (r_pos == '0) begin
                            r_state <= S_WALK_RD;
                        end else begin
                            r_pos   <= r_pos - IW'(1);
                            r_state <= S_DP_TOP;
                        end
                    end
                end
                S_DP_CMP: begin
                    if (cand_len > r_cur_len) begin
                        r_cur_len <= cand_len;
                        r_cur_hop <= LW'(r_v);
                    end
                    r_state <= S_DP_RD;
                end
                S_WALK_RD: begin
                    if (r_count == '0 && r_cur != r_start) begin
                        r_cur <= r_start;
                    end else begin
                        r_state <= S_WALK_EMIT;
                    end
                end
                S_WALK_EMIT: begin
                    if (out_free) begin
                        r_ostatus <= dlp_pkg::ST_PATH;
                        r_onode   <= r_cur;
                        r_olen    <= r_max;
                        r_olast   <= fin;
                        if (fin) begin
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_count <= r_count + IW'(1);
                            r_cur   <= r_nh_q[IW-1:0];
                            r_state <= S_WALK_RD;
                        end
                    end
                end
                S_EMIT1: begin
                    if (out_free) begin
                        r_ostatus <= r_pend;
                        r_onode   <= '0;
                        r_olen    <= '0;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_path_node    = r_onode;
    assign o_chain_length = r_olen;
    assign o_last         = r_olast;

endmodule

>>> rtl/core/dag_longest_path.sv
// ----------------------------------------------------------------------------
// dag_longest_path
// Longest chain in a directed graph of up to 64 nodes.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one item per request: add node, add
// edge, run, or clear. Items enter a four-entry queue; o_stall rises only
// when that queue is full.
// Output channel (o_valid / i_stall): a run gives one item per chain node,
// the final one with o_last set; a cycle or an empty graph gives a single
// item with o_last set. The output register holds its item while i_stall
// is high, and the back end waits for it to free.
// An add edge does a read-modify-write of one row of the edge memory. A
// run does an in-degree sweep, the sort and the chain pass, and then
// emits its items.
// Reset (synchronous, active low) empties the graph and the queue.
// ----------------------------------------------------------------------------
module dag_longest_path (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_req_type,
    input  logic [5:0] i_src_node,
    input  logic [5:0] i_dst_node,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [5:0] o_path_node,
    output logic [6:0] o_chain_length,
    output logic       o_last
);

    dlp_pkg::t_qhead head;
    logic            pop;

    dlp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_src_node (i_src_node),
        .i_dst_node (i_dst_node),
        .i_pop      (pop),
        .o_head     (head)
    );

    dlp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_path_node    (o_path_node),
        .o_chain_length (o_chain_length),
        .o_last         (o_last)
    );

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != dlp_pkg::ST_PATH |->
            o_path_node == '0 && o_chain_length == '0 && o_last)
        else $error("error item with nonzero fields");

    a_path_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == dlp_pkg::ST_PATH |->
            o_chain_length != '0 && o_chain_length <= 7'd64)
        else $error("chain length out of range");

    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.avail)
        else $error("pop without queued item");

endmodule
